/* hw/rtl/rtda_pkg.sv */
// Shared types, constants and sensor tables for the RTD divider thermometer.
package rtda_pkg;

  // Table sizes; the usable point count is capped at TABLE_POINTS.
  localparam int TABLE_POINTS = 21;
  localparam int KTY_POINTS   = 16;
  localparam int PT_POINTS    = 21;
  localparam int KTY_N = (KTY_POINTS < TABLE_POINTS) ? KTY_POINTS : TABLE_POINTS;
  localparam int PT_N  = (PT_POINTS < TABLE_POINTS) ? PT_POINTS : TABLE_POINTS;

  localparam logic [4:0] KTY_LAST     = 5'(KTY_N - 1);
  localparam logic [4:0] PT_LAST      = 5'(PT_N - 1);
  localparam logic [4:0] KTY_LAST_SEG = 5'(KTY_N - 2);
  localparam logic [4:0] PT_LAST_SEG  = 5'(PT_N - 2);

  // Configuration register indexes.
  localparam logic [1:0] REG_SENSOR_TYPE = 2'd0;
  localparam logic [1:0] REG_SUPPLY_MV   = 2'd1;
  localparam logic [1:0] REG_SERIES_OHMS = 2'd2;
  localparam logic [1:0] REG_SAMPLES     = 2'd3;

  localparam logic        SENSOR_PT1000   = 1'b1;

  // Register reset values.
  localparam logic [12:0] SUPPLY_RESET  = 13'd3300;
  localparam logic [15:0] SERIES_RESET  = 16'd4700;
  localparam logic [6:0]  SAMPLES_RESET = 7'd20;
  localparam logic [6:0]  WINDOW_MAX    = 7'd64;

  // Divider step counts per operation.
  localparam logic [5:0] RES_STEPS    = 6'd33;
  localparam logic [5:0] INTERP_STEPS = 6'd20;
  localparam logic [5:0] AVG_STEPS    = 6'd18;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_R,
    ST_DIV_R,
    ST_WAIT_R,
    ST_SEARCH,
    ST_MUL_I,
    ST_DIV_I,
    ST_WAIT_I,
    ST_ACCUM,
    ST_WAIT_A,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [12:0] divisor;
    logic [5:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quotient;
  } div_rsp_t;

  // Table resistance in tenths of an ohm.
  function automatic logic [15:0] tbl_res(input logic pt, input logic [4:0] idx);
    logic [15:0] res;
    res = 16'd0;
    if (pt == SENSOR_PT1000) begin
      case (idx)
        5'd0:  res = 16'd8427;
        5'd1:  res = 16'd8822;
        5'd2:  res = 16'd9216;
        5'd3:  res = 16'd9609;
        5'd4:  res = 16'd10000;
        5'd5:  res = 16'd10390;
        5'd6:  res = 16'd10779;
        5'd7:  res = 16'd10974;
        5'd8:  res = 16'd11167;
        5'd9:  res = 16'd11554;
        5'd10: res = 16'd11940;
        5'd11: res = 16'd12324;
        5'd12: res = 16'd12700;
        5'd13: res = 16'd13089;
        5'd14: res = 16'd13470;
        5'd15: res = 16'd13850;
        5'd16: res = 16'd14220;
        5'd17: res = 16'd14606;
        5'd18: res = 16'd14982;
        5'd19: res = 16'd15358;
        5'd20: res = 16'd15731;
        default: res = 16'd0;
      endcase
    end else begin
      case (idx)
        5'd0:  res = 16'd16300;
        5'd1:  res = 16'd17720;
        5'd2:  res = 16'd19220;
        5'd3:  res = 16'd20000;
        5'd4:  res = 16'd20800;
        5'd5:  res = 16'd22450;
        5'd6:  res = 16'd24170;
        5'd7:  res = 16'd25970;
        5'd8:  res = 16'd27850;
        5'd9:  res = 16'd29800;
        5'd10: res = 16'd31180;
        5'd11: res = 16'd33920;
        5'd12: res = 16'd38170;
        5'd13: res = 16'd40080;
        5'd14: res = 16'd41660;
        5'd15: res = 16'd42800;
        default: res = 16'd0;
      endcase
    end
    return res;
  endfunction

  // Table temperature in whole degrees Celsius.
  function automatic logic signed [8:0] tbl_deg(input logic pt, input logic [4:0] idx);
    logic signed [8:0] deg;
    deg = 9'sd0;
    if (pt == SENSOR_PT1000) begin
      case (idx)
        5'd0:  deg = -9'sd40;
        5'd1:  deg = -9'sd30;
        5'd2:  deg = -9'sd20;
        5'd3:  deg = -9'sd10;
        5'd4:  deg = 9'sd0;
        5'd5:  deg = 9'sd10;
        5'd6:  deg = 9'sd20;
        5'd7:  deg = 9'sd25;
        5'd8:  deg = 9'sd30;
        5'd9:  deg = 9'sd40;
        5'd10: deg = 9'sd50;
        5'd11: deg = 9'sd60;
        5'd12: deg = 9'sd70;
        5'd13: deg = 9'sd80;
        5'd14: deg = 9'sd90;
        5'd15: deg = 9'sd100;
        5'd16: deg = 9'sd110;
        5'd17: deg = 9'sd120;
        5'd18: deg = 9'sd130;
        5'd19: deg = 9'sd140;
        5'd20: deg = 9'sd150;
        default: deg = 9'sd0;
      endcase
    end else begin
      case (idx)
        5'd0:  deg = 9'sd0;
        5'd1:  deg = 9'sd10;
        5'd2:  deg = 9'sd20;
        5'd3:  deg = 9'sd25;
        5'd4:  deg = 9'sd30;
        5'd5:  deg = 9'sd40;
        5'd6:  deg = 9'sd50;
        5'd7:  deg = 9'sd60;
        5'd8:  deg = 9'sd70;
        5'd9:  deg = 9'sd80;
        5'd10: deg = 9'sd90;
        5'd11: deg = 9'sd100;
        5'd12: deg = 9'sd110;
        5'd13: deg = 9'sd120;
        5'd14: deg = 9'sd130;
        5'd15: deg = 9'sd140;
        default: deg = 9'sd0;
      endcase
    end
    return deg;
  endfunction

endpackage

/* hw/rtl/rtda_mult.sv */
// Shared 17x16 unsigned multiplier with registered product.
module rtda_mult (
  input  logic        clk,
  input  logic [16:0] a,
  input  logic [15:0] b,
  output logic [32:0] prod
);

  always_ff @(posedge clk) begin
    prod <= 33'(a) * 33'(b);
  end

endmodule

/* hw/rtl/rtda_divider.sv */
// Shared restoring divider, one quotient bit per cycle, MSB-aligned dividend.
module rtda_divider (
  input  logic               clk,
  input  logic               rst,
  input  rtda_pkg::div_req_t req,
  output rtda_pkg::div_rsp_t rsp
);

  logic        busy;
  logic [5:0]  cnt;
  logic [12:0] rem;
  logic [12:0] dsr;
  logic [32:0] dvd;
  logic [32:0] quo;
  logic        done;

  logic [13:0] shifted;
  logic [14:0] trial;

  assign shifted = {rem, dvd[32]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dsr <= req.divisor;
      dvd <= req.dividend;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[31:0], 1'b0};
      if (!trial[14]) begin
        rem <= trial[12:0];
        quo <= {quo[31:0], 1'b1};
      end else begin
        rem <= shifted[12:0];
        quo <= {quo[31:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* hw/rtl/rtd_divider_temperature_average.sv */
// Top level: RTD divider thermometer with window averaging.
//
// One sample_mv transfer in gives one result transfer out. The block first
// forms the sensor resistance R = floor(10*series_ohms*v/(supply_mv-v)) in
// tenths of an ohm, then walks the selected table (KTY81-210 or PT1000, set by
// sensor_type) one point per cycle to find the segment, and interpolates to
// get the temperature in 1/16 degC. Valid temperatures are summed; once
// samples_per_average valid samples are in (0 acts as 1, above 64 as 64) the
// mean truncated toward zero comes out with average_ready set, and the window
// restarts. A sample of zero, at or above supply_mv, or whose resistance lies
// outside the table returns all fields zero and leaves the window untouched.
// A valid sample occupies the block longer the higher the segment index
// found by the table walk (0 to 19 for PT1000, 0 to 14 for KTY81-210), and
// longer when it closes a window. A sample rejected by the voltage check skips
// the divider; one failing the resistance check ends after R. This rests on
// the single shared bit-serial divider (33 steps for R, 20 for interpolation,
// 18 for the mean) and the one-point-per-cycle table walk. s_axis_tready is
// high only while the sequencer is idle; the result sits in an output
// register, so the next sample is taken while the last result waits.
// Configuration writes are always accepted and belong in idle periods.
module rtd_divider_temperature_average (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // sample stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [12:0] sample_mv, [15:13] zero
  // result stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [12:0] sample_temp, [25:13] average_temp, [31:26] zero
  output logic [1:0]  m_axis_tuser    // [0] sample_valid, [1] average_ready
);

  // configuration registers
  logic        sensor_type;
  logic [12:0] supply_mv;
  logic [15:0] series_ohms;
  logic [6:0]  samples_per_average;

  // window state
  logic signed [18:0] temp_sum;
  logic [6:0]         sum_count;

  // sequencer
  rtda_pkg::state_t state;
  rtda_pkg::state_t state_next;

  // per-sample working registers
  logic [12:0]        v;
  logic [16:0]        v10;
  logic [15:0]        r;
  logic [4:0]         idx;
  logic signed [12:0] temp;
  logic               sum_neg;

  // pending result
  logic [12:0] res_temp;
  logic        res_valid;
  logic [12:0] res_avg;
  logic        res_ready;

  // shared units
  logic [16:0]        mul_a;
  logic [15:0]        mul_b;
  logic [32:0]        prod;
  rtda_pkg::div_req_t div_req;
  rtda_pkg::div_rsp_t div_rsp;

  // combinational helpers
  logic [12:0]        v_in;
  logic               v_bad;
  logic [4:0]         last_idx;
  logic [4:0]         last_seg;
  logic [4:0]         idx_up;
  logic [15:0]        rt_cur;
  logic [15:0]        rt_up;
  logic [15:0]        rt_first;
  logic [15:0]        rt_last;
  logic signed [8:0]  deg_cur;
  logic signed [8:0]  deg_up;
  logic signed [9:0]  deg_step;
  logic               r_out_of_range;
  logic               seg_found;
  logic signed [12:0] temp_base;
  logic signed [18:0] sum_new;
  logic [6:0]         cnt_new;
  logic [6:0]         win;
  logic               win_done;
  logic [18:0]        sum_mag;
  logic               out_free;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == rtda_pkg::ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign v_in  = s_axis_tdata[12:0];
  assign v_bad = (v_in == 13'd0) || (v_in >= supply_mv);

  assign last_idx = (sensor_type == rtda_pkg::SENSOR_PT1000) ? rtda_pkg::PT_LAST
                                                             : rtda_pkg::KTY_LAST;
  assign last_seg = (sensor_type == rtda_pkg::SENSOR_PT1000) ? rtda_pkg::PT_LAST_SEG
                                                             : rtda_pkg::KTY_LAST_SEG;
  assign idx_up   = idx + 5'd1;
  assign rt_cur   = rtda_pkg::tbl_res(sensor_type, idx);
  assign rt_up    = rtda_pkg::tbl_res(sensor_type, idx_up);
  assign rt_first = rtda_pkg::tbl_res(sensor_type, 5'd0);
  assign rt_last  = rtda_pkg::tbl_res(sensor_type, last_idx);
  assign deg_cur  = rtda_pkg::tbl_deg(sensor_type, idx);
  assign deg_up   = rtda_pkg::tbl_deg(sensor_type, idx_up);
  assign deg_step = 10'(deg_up) - 10'(deg_cur);

  // quotient is the full 33-bit resistance
  assign r_out_of_range = (div_rsp.quotient < 33'(rt_first)) ||
                          (div_rsp.quotient > 33'(rt_last));
  // first segment whose upper point is not below R; last segment otherwise
  assign seg_found = (idx == last_seg) || (r <= rt_up);

  assign temp_base = {deg_cur, 4'b0000};

  // window bookkeeping
  assign sum_new  = temp_sum + 19'(temp);
  assign cnt_new  = sum_count + 7'd1;
  assign win      = (samples_per_average == 7'd0) ? 7'd1 :
                    (samples_per_average > rtda_pkg::WINDOW_MAX) ? rtda_pkg::WINDOW_MAX :
                    samples_per_average;
  assign win_done = (cnt_new >= win);
  assign sum_mag  = sum_new[18] ? (19'd0 - sum_new) : sum_new;

  // shared multiplier: 10*v*series_ohms, then step*16*(R - R[i])
  always_comb begin
    mul_a = v10;
    mul_b = series_ohms;
    if (state == rtda_pkg::ST_MUL_I) begin
      mul_a = 17'(r - rt_cur);
      mul_b = {3'b000, deg_step[8:0], 4'b0000};
    end
  end

  rtda_mult u_mult (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // shared divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = prod;
    div_req.divisor  = supply_mv - v;
    div_req.steps    = rtda_pkg::RES_STEPS;
    case (state)
      rtda_pkg::ST_DIV_R: begin
        div_req.start = 1'b1;
      end
      rtda_pkg::ST_DIV_I: begin
        div_req.start    = 1'b1;
        div_req.dividend = {prod[19:0], 13'd0};
        div_req.divisor  = 13'(rt_up - rt_cur);
        div_req.steps    = rtda_pkg::INTERP_STEPS;
      end
      rtda_pkg::ST_ACCUM: begin
        div_req.start    = win_done;
        div_req.dividend = {sum_mag[17:0], 15'd0};
        div_req.divisor  = {6'd0, cnt_new};
        div_req.steps    = rtda_pkg::AVG_STEPS;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  rtda_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rtda_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_next = v_bad ? rtda_pkg::ST_OUT : rtda_pkg::ST_MUL_R;
      end
      rtda_pkg::ST_MUL_R: state_next = rtda_pkg::ST_DIV_R;
      rtda_pkg::ST_DIV_R: state_next = rtda_pkg::ST_WAIT_R;
      rtda_pkg::ST_WAIT_R: begin
        if (div_rsp.done) begin
          state_next = r_out_of_range ? rtda_pkg::ST_OUT : rtda_pkg::ST_SEARCH;
        end
      end
      rtda_pkg::ST_SEARCH: begin
        if (seg_found) state_next = rtda_pkg::ST_MUL_I;
      end
      rtda_pkg::ST_MUL_I: state_next = rtda_pkg::ST_DIV_I;
      rtda_pkg::ST_DIV_I: state_next = rtda_pkg::ST_WAIT_I;
      rtda_pkg::ST_WAIT_I: begin
        if (div_rsp.done) state_next = rtda_pkg::ST_ACCUM;
      end
      rtda_pkg::ST_ACCUM: state_next = win_done ? rtda_pkg::ST_WAIT_A : rtda_pkg::ST_OUT;
      rtda_pkg::ST_WAIT_A: begin
        if (div_rsp.done) state_next = rtda_pkg::ST_OUT;
      end
      rtda_pkg::ST_OUT: begin
        if (out_free) state_next = rtda_pkg::ST_IDLE;
      end
      default: state_next = rtda_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtda_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_type         <= 1'b0;
      supply_mv           <= rtda_pkg::SUPPLY_RESET;
      series_ohms         <= rtda_pkg::SERIES_RESET;
      samples_per_average <= rtda_pkg::SAMPLES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rtda_pkg::REG_SENSOR_TYPE: sensor_type         <= cfg_data[0];
        rtda_pkg::REG_SUPPLY_MV:   supply_mv           <= cfg_data[12:0];
        rtda_pkg::REG_SERIES_OHMS: series_ohms         <= cfg_data;
        rtda_pkg::REG_SAMPLES:     samples_per_average <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // window state: changes only when a valid sample is folded in
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_sum  <= '0;
      sum_count <= '0;
    end else if (state == rtda_pkg::ST_ACCUM) begin
      temp_sum  <= win_done ? 19'sd0 : sum_new;
      sum_count <= win_done ? 7'd0 : cnt_new;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      rtda_pkg::ST_IDLE: begin
        v         <= v_in;
        v10       <= {1'b0, v_in, 3'b000} + {3'b000, v_in, 1'b0};
        res_temp  <= '0;
        res_valid <= 1'b0;
        res_avg   <= '0;
        res_ready <= 1'b0;
      end
      rtda_pkg::ST_WAIT_R: begin
        r   <= div_rsp.quotient[15:0];
        idx <= '0;
      end
      rtda_pkg::ST_SEARCH: begin
        if (!seg_found) idx <= idx_up;
      end
      rtda_pkg::ST_WAIT_I: begin
        temp <= temp_base + $signed({4'b0000, div_rsp.quotient[8:0]});
      end
      rtda_pkg::ST_ACCUM: begin
        res_temp  <= temp;
        res_valid <= 1'b1;
        sum_neg   <= sum_new[18];
      end
      rtda_pkg::ST_WAIT_A: begin
        res_avg   <= sum_neg ? (13'd0 - div_rsp.quotient[12:0]) : div_rsp.quotient[12:0];
        res_ready <= 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == rtda_pkg::ST_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rtda_pkg::ST_OUT && out_free) begin
      m_axis_tdata <= {6'd0, res_avg, res_temp};
      m_axis_tuser <= {res_ready, res_valid};
    end
  end

endmodule

/* hw/rtl/rtda_checker.sv */
// Port-level checks for the RTD divider thermometer, bound to the top level.
module rtda_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // one sample at a time: busy right after a transfer in
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a sample is in work");

  // rejected sample carries all-zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'd0 && !m_axis_tuser[1])
    else $error("invalid result with nonzero fields");

  // mean field is zero unless a window closed
  a_avg_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[25:13] == 13'd0)
    else $error("average field set without average_ready");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

endmodule

bind rtd_divider_temperature_average rtda_checker u_rtda_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* bench/rtd_divider_temperature_average_tb.sv */
// Self-checking bench for the RTD divider thermometer: random samples against a shadow predictor.
module rtd_divider_temperature_average_tb;

  localparam int HALF_PERIOD = 4;
  localparam int STALL_LIMIT = 3000;  // cycles with no transfer on any channel
  localparam int LONG_HOLD   = 400;   // receiver hold-off that backs the block up
  localparam int SETTLE      = 160;   // covers the slowest sample (walk + mean)

  typedef enum logic [1:0] {OP_SAMPLE, OP_WRITE, OP_DRAIN} op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [1:0]  index;
    logic [15:0] data;
  } op_t;

  typedef struct packed {
    logic signed [12:0] temp;
    logic               valid;
    logic signed [12:0] avg;
    logic               ready;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = rtda_pkg::REG_SENSOR_TYPE;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [12:0] sample_mv, [15:13] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [12:0] sample_temp, [25:13] average_temp, [31:26] zero
  logic [1:0]  m_axis_tuser;        // [0] sample_valid, [1] average_ready

  rtd_divider_temperature_average dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Sensor curves, resistance in tenths of an ohm and temperature in degrees.
  int kty_res [16] = '{16300, 17720, 19220, 20000, 20800, 22450, 24170, 25970,
                       27850, 29800, 31180, 33920, 38170, 40080, 41660, 42800};
  int kty_deg [16] = '{0, 10, 20, 25, 30, 40, 50, 60, 70, 80, 90, 100, 110, 120, 130, 140};
  int pt_res  [21] = '{8427, 8822, 9216, 9609, 10000, 10390, 10779, 10974, 11167, 11554,
                       11940, 12324, 12700, 13089, 13470, 13850, 14220, 14606, 14982, 15358,
                       15731};
  int pt_deg  [21] = '{-40, -30, -20, -10, 0, 10, 20, 25, 30, 40, 50, 60, 70, 80, 90, 100,
                       110, 120, 130, 140, 150};

  // Shadow of the block: registers as written, plus the averaging window.
  bit cur_pt     = 1'b0;
  int cur_supply = rtda_pkg::SUPPLY_RESET;
  int cur_series = rtda_pkg::SERIES_RESET;
  int cur_window = rtda_pkg::SAMPLES_RESET;
  int win_sum    = 0;
  int win_count  = 0;

  // Stimulus side view of the registers, used to aim samples into the table.
  bit plan_pt     = 1'b0;
  int plan_supply = rtda_pkg::SUPPLY_RESET;
  int plan_series = rtda_pkg::SERIES_RESET;

  op_t      pending_ops [$];
  reading_t expected_readings [$];

  int  samples_queued = 0, samples_sent = 0, readings_checked = 0;
  int  writes_queued = 0, writes_done = 0;
  int  errors = 0;
  int  send_gap = 0, recv_stall = 0, hold_left = 0;
  int  hold_asked = 0, hold_given = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;

  function automatic int point_res(input bit pt, input int i);
    return pt ? pt_res[i] : kty_res[i];
  endfunction

  function automatic int point_deg(input bit pt, input int i);
    return pt ? pt_deg[i] : kty_deg[i];
  endfunction

  // Divider voltage -> temperature in 1/16 degC; 0 when out of range.
  function automatic bit divider_to_temp(input int mv, output int temp);
    longint r, num;
    int n, i, den;
    temp = 0;
    if (mv == 0 || mv >= cur_supply) return 1'b0;
    n = cur_pt ? rtda_pkg::PT_N : rtda_pkg::KTY_N;
    r = (longint'(cur_series) * 10 * mv) / (cur_supply - mv);
    if (r < point_res(cur_pt, 0) || r > point_res(cur_pt, n - 1)) return 1'b0;
    // first segment whose upper point is at or above r
    i = 0;
    while (i < n - 2 && r > point_res(cur_pt, i + 1)) i++;
    num = longint'(point_deg(cur_pt, i + 1) - point_deg(cur_pt, i)) * 16 *
          (r - point_res(cur_pt, i));
    den = point_res(cur_pt, i + 1) - point_res(cur_pt, i);
    temp = point_deg(cur_pt, i) * 16 + int'(num / den);
    return 1'b1;
  endfunction

  // Expected result of one accepted sample; advances the window.
  function automatic reading_t predict_reading(input int mv);
    reading_t rd;
    int t, win;
    rd = '0;
    if (!divider_to_temp(mv, t)) return rd;
    win = (cur_window == 0) ? 1 :
          ((cur_window > rtda_pkg::WINDOW_MAX) ? rtda_pkg::WINDOW_MAX : cur_window);
    win_sum += t;
    win_count = (win_count + 1) & 127;
    rd.temp  = 13'(t);
    rd.valid = 1'b1;
    // a shrunk window closes at once if the count already reaches it
    if (win_count >= win) begin
      rd.avg   = 13'(win_sum / win_count);
      rd.ready = 1'b1;
      win_sum   = 0;
      win_count = 0;
    end
    return rd;
  endfunction

  function automatic int clamp_mv(input longint v);
    if (v < 0) return 0;
    if (v > 8191) return 8191;
    return int'(v);
  endfunction

  // Voltage at which the divider shows a given resistance (tenths of an ohm).
  function automatic longint mv_for_res(input longint target);
    return (target * plan_supply) / (longint'(plan_series) * 10 + target);
  endfunction

  // Mostly samples aimed into the table, some anywhere, some on the edges.
  function automatic int pick_sample();
    int roll, lo, hi;
    lo = point_res(plan_pt, 0);
    hi = point_res(plan_pt, (plan_pt ? rtda_pkg::PT_N : rtda_pkg::KTY_N) - 1);
    roll = $urandom_range(99);
    if (roll < 72)
      return clamp_mv(mv_for_res($urandom_range(hi + hi / 32, lo - lo / 32)) +
                      int'($urandom_range(2)) - 1);
    if (roll < 88) return $urandom_range(8191);
    case ($urandom_range(7))
      0:       return 0;
      1:       return 1;
      2:       return clamp_mv(plan_supply - 1);
      3:       return clamp_mv(plan_supply);
      4:       return clamp_mv(plan_supply + 1);
      5:       return 8191;
      6:       return clamp_mv(mv_for_res(lo) + $urandom_range(1));
      default: return clamp_mv(mv_for_res(hi) + $urandom_range(1));
    endcase
  endfunction

  function automatic void queue_sample(input int mv);
    pending_ops.push_back('{OP_SAMPLE, '0, 16'(mv)});
    samples_queued++;
  endfunction

  // Everything sent has come back and every write has landed.
  task automatic wait_drained();
    while (pending_ops.size() != 0 || readings_checked != samples_queued ||
           writes_done != writes_queued)
      @(posedge clk);
  endtask

  // One run of samples under one register setting. Writes go in only while the
  // block is idle; the upper data bits of narrow registers carry junk.
  task automatic run_phase(input bit write_regs, input bit pt, input int supply,
                           input int series, input int window, input int count,
                           input bit edges, input bit pause_mid);
    int lo, hi;
    if (write_regs) begin
      pending_ops.push_back('{OP_WRITE, rtda_pkg::REG_SENSOR_TYPE,
                              {15'($urandom), 1'(pt)}});
      pending_ops.push_back('{OP_WRITE, rtda_pkg::REG_SUPPLY_MV,
                              {3'($urandom), 13'(supply)}});
      pending_ops.push_back('{OP_WRITE, rtda_pkg::REG_SERIES_OHMS, 16'(series)});
      pending_ops.push_back('{OP_WRITE, rtda_pkg::REG_SAMPLES,
                              {9'($urandom), 7'(window)}});
      writes_queued += 4;
      plan_pt     = pt;
      plan_supply = supply;
      plan_series = series;
    end
    if (edges) begin
      // zero, around the supply, full scale, and both ends of the table
      lo = point_res(plan_pt, 0);
      hi = point_res(plan_pt, (plan_pt ? rtda_pkg::PT_N : rtda_pkg::KTY_N) - 1);
      queue_sample(0);
      queue_sample(1);
      queue_sample(clamp_mv(plan_supply - 1));
      queue_sample(clamp_mv(plan_supply));
      queue_sample(8191);
      queue_sample(clamp_mv(mv_for_res(lo)));
      queue_sample(clamp_mv(mv_for_res(lo) + 1));
      queue_sample(clamp_mv(mv_for_res(hi)));
      queue_sample(clamp_mv(mv_for_res(hi) + 1));
    end
    for (int k = 0; k < count; k++) begin
      if (pause_mid && k == count / 2) pending_ops.push_back('{OP_DRAIN, '0, '0});
      queue_sample(pick_sample());
    end
    wait_drained();
    repeat (4) @(posedge clk);
  endtask

  // Sender: one transfer in flight at a time over both channels, next item from the queue after any random gap.
  always @(posedge clk) begin : sender
    op_t  op;
    logic nxt_s, nxt_c;
    if (!rst) begin
      nxt_s = s_axis_tvalid;
      nxt_c = cfg_valid;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rtda_pkg::REG_SENSOR_TYPE: cur_pt     = cfg_data[0];
          rtda_pkg::REG_SUPPLY_MV:   cur_supply = cfg_data[12:0];
          rtda_pkg::REG_SERIES_OHMS: cur_series = cfg_data;
          rtda_pkg::REG_SAMPLES:     cur_window = cfg_data[6:0];
          default: ;
        endcase
        writes_done++;
        nxt_c = 1'b0;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_readings.push_back(predict_reading(s_axis_tdata[12:0]));
        samples_sent++;
        nxt_s = 1'b0;
      end
      if (!nxt_s && !nxt_c) begin
        if (send_gap > 0)
          send_gap--;
        else if (!calm && $urandom_range(2) == 0)
          send_gap = $urandom_range(14);          // start a random burst of idle cycles
        else if (pending_ops.size() != 0) begin
          op = pending_ops[0];
          case (op.kind)
            OP_SAMPLE: begin
              void'(pending_ops.pop_front());
              s_axis_tdata <= op.data;
              nxt_s = 1'b1;
            end
            OP_WRITE: begin
              void'(pending_ops.pop_front());
              cfg_index <= op.index;
              cfg_data  <= op.data;
              nxt_c = 1'b1;
            end
            default: begin
              // pause until every result so far is back
              if (readings_checked == samples_sent) void'(pending_ops.pop_front());
            end
          endcase
        end
      end
      s_axis_tvalid <= nxt_s;
      cfg_valid     <= nxt_c;
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Receiver: compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : receiver
    reading_t want;
    logic     nxt_ready;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        readings_checked++;
        if (expected_readings.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, actual tdata %h tuser %b",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = expected_readings.pop_front();
          check_field("sample_temp", want.temp, $signed(m_axis_tdata[12:0]));
          check_field("sample_valid", want.valid, m_axis_tuser[0]);
          check_field("average_temp", want.avg, $signed(m_axis_tdata[25:13]));
          check_field("average_ready", want.ready, m_axis_tuser[1]);
        end
      end
      if (hold_asked != hold_given) begin
        hold_given++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        nxt_ready = 1'b0;
      end else if (!calm && $urandom_range(4) == 0) begin
        recv_stall = $urandom_range(14);          // start a random burst of stalled cycles
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      m_axis_tready <= nxt_ready;
    end
  end

  // Watchdog: too long without any transfer means the block is stuck.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("rtd_divider_temperature_average_tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int supply, series, window, roll;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset setting (KTY81-210), then PT1000 with a zero window
    // (acts as one, so every valid sample reports a mean).
    run_phase(1'b0, 1'b0, 0, 0, 0, 3, 1'b1, 1'b0);
    run_phase(1'b1, 1'b1, 3300, 4700, 0, 1, 1'b1, 1'b0);

    // Oversized window (acts as 64) at top supply and resistor, with a pause
    // of the sender in the middle; then keep filling a 64 window and shrink
    // it to 2 so the open window closes at once.
    run_phase(1'b1, 1'b0, 8191, 65535, 100, 80, 1'b0, 1'b1);
    run_phase(1'b1, 1'b0, 8191, 65535, 64, 12, 1'b0, 1'b0);
    run_phase(1'b1, 1'b1, 1000, 100, 2, 60, 1'b0, 1'b0);

    // Random settings; one phase with a long receiver hold-off.
    for (int p = 0; p < 9; p++) begin
      roll = $urandom_range(19);
      supply = (roll < 2) ? 8191 : (roll < 4) ? 1000 : (roll < 5) ? $urandom_range(999, 1)
                                                                  : $urandom_range(8191, 1000);
      roll = $urandom_range(19);
      series = (roll < 2) ? 65535 : (roll < 4) ? 100 : (roll < 5) ? $urandom_range(99)
                                                                  : $urandom_range(65535, 100);
      roll = $urandom_range(9);
      window = (roll < 5) ? $urandom_range(8, 1) : (roll < 7) ? $urandom_range(64, 9)
             : (roll < 8) ? 64 : (roll < 9) ? 0 : $urandom_range(127, 65);
      if (p == 3) hold_asked++;
      run_phase(1'b1, $urandom_range(1), supply, series, window, 90, 1'b0, p % 3 == 1);
    end

    // Last stretch with no idling on either side, one-sample window.
    calm = 1'b1;
    run_phase(1'b1, $urandom_range(1), $urandom_range(8191, 1000), $urandom_range(65535, 100),
              1, 100, 1'b0, 1'b0);

    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("rtd_divider_temperature_average_tb OK");
    else
      $display("rtd_divider_temperature_average_tb NOT OK");
    $finish;
  end

endmodule
